// ===== src/pmul_pkg.sv =====
`default_nettype none
package pmul_pkg;

  localparam int DEG_W     = 5;
  localparam int CIDX_W    = 5;
  localparam int CVAL_W    = 16;
  localparam int OPC_W     = 2;
  localparam int VALUE_W   = 37;
  localparam int PIDX_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [OPC_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OPC_W-1:0] OP_MULTIPLY    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DEGREE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DEGREE = 1'd1;

  typedef struct packed {
    logic step;
    logic clear;
  } pmul_ctl_t;

endpackage
`default_nettype wire

// ===== src/pmul_cell.sv =====
`default_nettype none
module pmul_cell
  import pmul_pkg::*;
#(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pmul_ctl_t                    ctl,
  input  wire logic                         we_first,
  input  wire logic                         we_second,
  input  wire logic        [COEF_WIDTH-1:0] wr_coef,
  input  wire logic                         active,
  input  wire logic signed [COEF_WIDTH-1:0] x,
  input  wire logic signed [VALUE_W-1:0]    sum_in,
  output logic signed [VALUE_W-1:0]         sum_out,
  output logic signed [COEF_WIDTH-1:0]      second_coef
);

  localparam int PROD_W = 2 * COEF_WIDTH;
  localparam int EXT_W  = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

  logic signed [COEF_WIDTH-1:0] first_coef;
  logic signed [COEF_WIDTH-1:0] p_eff;
  logic signed [PROD_W-1:0]     prod;
  logic signed [EXT_W-1:0]      prod_ext;
  logic signed [VALUE_W-1:0]    mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_coef  <= '0;
      second_coef <= '0;
    end else begin
      if (we_first)  first_coef  <= wr_coef;
      if (we_second) second_coef <= wr_coef;
    end
  end

  assign p_eff    = active ? first_coef : '0;
  assign prod     = p_eff * x;
  assign prod_ext = EXT_W'(prod);
  assign mac      = prod_ext[VALUE_W-1:0] + sum_in;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_out <= '0;
    end else if (ctl.step) begin
      sum_out <= mac;
    end
  end

endmodule
`default_nettype wire

// ===== src/polynomial_multiply_core.sv =====
// Polynomial multiplier, signed integer coefficients.
// Input stream (s_*): each transaction is a load of one coefficient of the
// first or second polynomial, or a multiply request. Loads above the
// configured degree are dropped.
// Output stream (m_*): a multiply yields first_degree+second_degree+1
// transactions, product coefficient 0 first; m_tlast marks the top one.
// Accepting a multiply moves the state to ST_RUN; the first result is then
// registered, and results follow one per cycle while m_tready is high, set
// by the chain of multiply-accumulate cells (one per coefficient of the
// first polynomial) that passes partial sums towards cell 0 on each step.
// Input is taken only when no multiply is running and the output register
// is free or being drained, so no new transaction enters until a multiply
// has stepped out its last product coefficient.
// A low m_tready freezes the cell chain; no result is lost. The user must
// write degrees via cfg_* only while idle; the block does not check it.
// Reset (rst, synchronous) zeroes both coefficient stores and degrees.
`default_nettype none
module polynomial_multiply_core
  import pmul_pkg::*;
#(
  parameter int DEGREE_LIMIT = 31,
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DEG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // opcode[1:0], coef_index[6:2], coef_value[22:7], zero pad [23]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // product_value[36:0], product_index[42:37], zero pad [47:43]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast
);

  localparam int CELLS = DEGREE_LIMIT + 1;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RAW_W = (COEF_WIDTH > CVAL_W) ? COEF_WIDTH : CVAL_W;
  localparam logic [DEG_W-1:0] MAX_D = DEG_W'(DEGREE_LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  logic [DEG_W-1:0]  first_degree;
  logic [DEG_W-1:0]  second_degree;
  logic [DEG_W-1:0]  m_deg;
  logic [DEG_W-1:0]  n_deg;
  logic [PIDX_W-1:0] top;
  logic [PIDX_W-1:0] t;
  logic [PIDX_W-1:0] product_index;
  logic              out_valid;
  logic              out_last;

  logic [OPC_W-1:0]  opcode;
  logic [CIDX_W-1:0] coef_index;
  logic [CVAL_W-1:0] coef_value;
  logic [RAW_W-1:0]  coef_raw;
  logic [COEF_WIDTH-1:0] wr_coef;
  logic in_fire;
  logic load_first;
  logic load_second;
  logic start;
  logic step;
  pmul_ctl_t ctl;

  logic signed [COEF_WIDTH-1:0] x;
  logic signed [COEF_WIDTH-1:0] second_all [CELLS];
  logic signed [VALUE_W-1:0]    sums [CELLS+1];

  assign opcode     = s_tdata[OPC_W-1:0];
  assign coef_index = s_tdata[OPC_W +: CIDX_W];
  assign coef_value = s_tdata[OPC_W+CIDX_W +: CVAL_W];
  assign coef_raw   = RAW_W'(coef_value);
  assign wr_coef    = coef_raw[COEF_WIDTH-1:0];

  assign m_deg = (first_degree  > MAX_D) ? MAX_D : first_degree;
  assign n_deg = (second_degree > MAX_D) ? MAX_D : second_degree;
  assign top   = {1'b0, m_deg} + {1'b0, n_deg};

  assign s_tready    = (state == ST_IDLE) && (!out_valid || m_tready);
  assign in_fire     = s_tvalid && s_tready;
  assign load_first  = in_fire && (opcode == OP_LOAD_FIRST)  && (coef_index <= m_deg);
  assign load_second = in_fire && (opcode == OP_LOAD_SECOND) && (coef_index <= n_deg);
  assign start       = in_fire && (opcode == OP_MULTIPLY);
  assign step        = (state == ST_RUN) && (!out_valid || m_tready);

  assign ctl.step  = step;
  assign ctl.clear = start;

  assign x = (t <= {1'b0, n_deg}) ? second_all[t[IDX_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_degree  <= '0;
      second_degree <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_DEGREE:  first_degree  <= cfg_data;
        REG_SECOND_DEGREE: second_degree <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      t         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            t     <= '0;
          end
        end
        ST_RUN: begin
          if (step) begin
            if (t == top) begin
              state <= ST_IDLE;
            end else begin
              t <= t + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      product_index <= t;
      out_last      <= (t == top);
    end
  end

  assign sums[CELLS] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    pmul_cell #(
      .COEF_WIDTH(COEF_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .we_first   (load_first  && (coef_index == CIDX_W'(i))),
      .we_second  (load_second && (coef_index == CIDX_W'(i))),
      .wr_coef    (wr_coef),
      .active     (DEG_W'(i) <= m_deg),
      .x          (x),
      .sum_in     (sums[i+1]),
      .sum_out    (sums[i]),
      .second_coef(second_all[i])
    );
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_DATA_W-VALUE_W-PIDX_W){1'b0}}, product_index, sums[0]};

endmodule
`default_nettype wire

// ===== tb/sv/polynomial_multiply_core_test.sv =====
`timescale 1ns / 1ps
module polynomial_multiply_core_test;
  import pmul_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_FROM = 265;
  localparam int ITEM_COUNT = 310;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     sel;
    logic [DEG_W-1:0]         deg;
    logic [OPC_W-1:0]         opc;
    logic [CIDX_W-1:0]        idx;
    logic [CVAL_W-1:0]        val;
    bit                       typed;
    logic signed [VALUE_W-1:0] want;
  } row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PIDX_W-1:0]  power;
    logic               last;
  } coeff_t;

  // typed rows hold a single product coefficient at power 0
  localparam row_t PLAN [0:26] = '{
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b1, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd0, 16'h8000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_SECOND, 5'd0, 16'h8000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b1, 37'sd1073741824},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd0, 16'h7fff, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b1, -37'sd1073709056},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_UNUSED, 5'd31, 16'hffff, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd1, 16'h0005, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_SECOND, 5'd31, 16'h7fff, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b1, -37'sd1073709056},
    '{ROW_CFG, REG_FIRST_DEGREE, 5'd31, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_CFG, REG_SECOND_DEGREE, 5'd31, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd31, 16'h8000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_SECOND, 5'd31, 16'h8000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_SECOND, 5'd5, 16'h04d2, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_CFG, REG_FIRST_DEGREE, 5'd2, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_CFG, REG_SECOND_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd3, 16'h004d, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_SECOND, 5'd1, 16'h0009, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd2, 16'hffff, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b0, 37'sd0},
    // raising the degree brings back the entries written earlier
    '{ROW_CFG, REG_SECOND_DEGREE, 5'd31, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_CFG, REG_FIRST_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_CFG, REG_SECOND_DEGREE, 5'd0, OP_LOAD_FIRST, 5'd0, 16'h0000, 1'b0, 37'sd0},
    '{ROW_ITEM, REG_FIRST_DEGREE, 5'd0, OP_MULTIPLY, 5'd0, 16'h0000, 1'b1, -37'sd1073709056}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DEG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  logic signed [CVAL_W-1:0] first_coef [0:31];
  logic signed [CVAL_W-1:0] second_coef [0:31];
  logic [DEG_W-1:0]         first_deg = '0;
  logic [DEG_W-1:0]         second_deg = '0;
  coeff_t                   pending_coeffs [$];

  bit quiet = 1'b0;
  bit send_gaps = 1'b0;
  bit recv_stalls = 1'b0;
  int items_sent = 0;
  int multiplies = 0;
  int coeffs_checked = 0;
  int errors = 0;

  polynomial_multiply_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  initial begin
    #10_000_000;
    $display("timeout with %0d coefficients outstanding", pending_coeffs.size());
    $display("[polynomial_multiply_core] ERROR");
    $finish;
  end

  function automatic void predict_coefficients(logic [OPC_W-1:0] opc,
                                               logic [CIDX_W-1:0] idx,
                                               logic signed [CVAL_W-1:0] val);
    longint acc;
    int top;
    coeff_t c;
    case (opc)
      OP_LOAD_FIRST: if (idx <= first_deg) first_coef[idx] = val;
      OP_LOAD_SECOND: if (idx <= second_deg) second_coef[idx] = val;
      OP_MULTIPLY: begin
        top = first_deg + second_deg;
        for (int k = 0; k <= top; k++) begin
          acc = 0;
          for (int i = 0; i <= k; i++) begin
            if (i <= first_deg && k - i <= second_deg)
              acc += longint'(first_coef[i]) * longint'(second_coef[k - i]);
          end
          c.value = acc[VALUE_W-1:0];
          c.power = k[PIDX_W-1:0];
          c.last = (k == top);
          pending_coeffs.insert(pending_coeffs.size(), c);
        end
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send(input logic [OPC_W-1:0] opc, input logic [CIDX_W-1:0] idx,
                      input logic [CVAL_W-1:0] val, input bit typed,
                      input logic signed [VALUE_W-1:0] want);
    coeff_t c;
    if (!quiet && send_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, val, idx, opc};
    do @(posedge clk); while (!s_tready);
    if (typed) begin
      c.value = want;
      c.power = '0;
      c.last = 1'b1;
      pending_coeffs.insert(pending_coeffs.size(), c);
    end else begin
      predict_coefficients(opc, idx, val);
    end
    items_sent++;
    if (opc == OP_MULTIPLY) multiplies++;
    @(negedge clk);
  endtask

  task automatic set_degree(input logic [CFG_IDX_W-1:0] sel, input logic [DEG_W-1:0] d);
    s_tvalid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_FIRST_DEGREE) first_deg = d;
    else second_deg = d;
  endtask

  function automatic logic [CVAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return CVAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [DEG_W-1:0] pick_degree();
    case ($urandom_range(0, 11))
      0: return 5'd31;
      1: return 5'd0;
      default: return DEG_W'($urandom_range(0, 6));
    endcase
  endfunction

  // junk between loads: unused opcode or a write above the degree
  task automatic send_noise();
    logic [DEG_W-1:0] d;
    logic [OPC_W-1:0] opc;
    opc = $urandom_range(0, 1) ? OP_LOAD_SECOND : OP_LOAD_FIRST;
    d = (opc == OP_LOAD_FIRST) ? first_deg : second_deg;
    if (d == 5'd31 || $urandom_range(0, 2) == 0)
      send(OP_UNUSED, CIDX_W'($urandom), CVAL_W'($urandom), 1'b0, '0);
    else
      send(opc, CIDX_W'($urandom_range(d + 1, 31)), pick_value(), 1'b0, '0);
  endtask

  always begin
    @(negedge clk);
    if (!quiet && recv_stalls && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    coeff_t got;
    coeff_t want;
    bit have;
    if (!rst && m_tvalid && m_tready) begin
      got.value = m_tdata[VALUE_W-1:0];
      got.power = m_tdata[VALUE_W+PIDX_W-1:VALUE_W];
      got.last = m_tlast;
      have = (pending_coeffs.size() != 0);
      want = have ? pending_coeffs.pop_front() : '0;
      coeffs_checked++;
      if (!have || got !== want) begin
        errors++;
        if (errors <= 10) begin
          if (!have)
            $display("%0t: unexpected coefficient value %0d power %0d last %0b", $realtime,
                     $signed(got.value), got.power, got.last);
          else
            $display("%0t: expected value %0d power %0d last %0b, got %0d power %0d last %0b",
                     $realtime, $signed(want.value), want.power, want.last,
                     $signed(got.value), got.power, got.last);
        end
      end
    end
  end

  initial begin
    logic [DEG_W-1:0] m;
    logic [DEG_W-1:0] n;
    int span;
    for (int i = 0; i < 32; i++) begin
      first_coef[i] = '0;
      second_coef[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < $size(PLAN); r++) begin
      if (PLAN[r].kind == ROW_CFG)
        set_degree(PLAN[r].sel, PLAN[r].deg);
      else
        send(PLAN[r].opc, PLAN[r].idx, PLAN[r].val, PLAN[r].typed, PLAN[r].want);
    end

    while (items_sent < ITEM_COUNT) begin
      send_gaps = ($urandom_range(0, 2) != 0);
      recv_stalls = ($urandom_range(0, 2) != 0);
      m = pick_degree();
      n = pick_degree();
      if (m != first_deg || $urandom_range(0, 3) == 0) set_degree(REG_FIRST_DEGREE, m);
      if (n != second_deg || $urandom_range(0, 3) == 0) set_degree(REG_SECOND_DEGREE, n);
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      span = (m > n) ? m : n;
      for (int k = 0; k <= span; k++) begin
        if (k <= m && $urandom_range(0, 3) != 0)
          send(OP_LOAD_FIRST, CIDX_W'(k), pick_value(), 1'b0, '0);
        if (k <= n && $urandom_range(0, 3) != 0)
          send(OP_LOAD_SECOND, CIDX_W'(k), pick_value(), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) send_noise();
      end
      send(OP_MULTIPLY, CIDX_W'($urandom), CVAL_W'($urandom), 1'b0, '0);
      if ($urandom_range(0, 3) == 0) begin
        send(OP_LOAD_FIRST, CIDX_W'($urandom_range(0, m)), pick_value(), 1'b0, '0);
        send(OP_MULTIPLY, CIDX_W'($urandom), CVAL_W'($urandom), 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d input transactions including %0d multiplies", items_sent, multiplies);
    $display("checked %0d product coefficients, %0d mismatches", coeffs_checked, errors);
    if (errors == 0 && pending_coeffs.size() == 0)
      $display("[polynomial_multiply_core] OK");
    else
      $display("[polynomial_multiply_core] ERROR");
    $finish;
  end

endmodule

// ===== polynomial_multiply_core.f =====
src/pmul_pkg.sv
src/pmul_cell.sv
src/polynomial_multiply_core.sv
tb/sv/polynomial_multiply_core_test.sv
